// ----- rtl/bpo_pkg.sv -----
// Shared types and constants for the box pair overlap push vector block.
// No dependencies; imported by the front, queue, back and top level modules.
package bpo_pkg;

	localparam int FIFO_DEPTH = 4;

	// Per-request control flags that travel from the front to the back.
	typedef struct packed {
		logic       hit;
		logic       push_en;
		logic [2:0] neg;
	} bpo_flags_t;

	localparam int FLAGS_W = $bits(bpo_flags_t);

endpackage

// ----- rtl/bpo_front.sv -----
// Front end: world transform, overlap test, dominant axis and velocity squares.
// Depends on bpo_pkg.
module bpo_front #(
	parameter int W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [3*W-1:0]             box_a_min,
	input  logic [3*W-1:0]             box_a_max,
	input  logic [3*W-1:0]             box_b_min,
	input  logic [3*W-1:0]             box_b_max,
	input  logic [3*W-1:0]             position_a,
	input  logic [3*W-1:0]             position_b,
	input  logic [3*W-1:0]             shift_a,
	input  logic [3*W-1:0]             shift_b,
	input  logic [3*W-1:0]             velocity_a,
	input  logic                       a_has_body,
	output logic                       req_valid,
	input  logic                       req_ready,
	output bpo_pkg::bpo_flags_t        req_flags,
	output logic [2:0][2*W-2:0]        req_sq,
	output logic [2*W-1:0]             req_sum,
	output logic [W-1:0]               req_dm
);
	import bpo_pkg::*;

	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_add = s[W] ? SMIN : SMAX;
		end else begin
			sat_add = s[W-1:0];
		end
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_sub = s[W] ? SMIN : SMAX;
		end else begin
			sat_sub = s[W-1:0];
		end
	endfunction

	logic                    adv;
	logic signed [W-1:0]     amin_d [0:2];
	logic signed [W-1:0]     amax_d [0:2];
	logic signed [W-1:0]     bmin_d [0:2];
	logic signed [W-1:0]     bmax_d [0:2];
	logic                    valid_s1;
	logic                    body_s1;
	logic signed [W-1:0]     amin_s1 [0:2];
	logic signed [W-1:0]     amax_s1 [0:2];
	logic signed [W-1:0]     bmin_s1 [0:2];
	logic signed [W-1:0]     bmax_s1 [0:2];
	logic signed [W-1:0]     vel_s1 [0:2];
	logic                    hit_d;
	logic [W-1:0]            av [0:2];
	logic [2:0]              ksel;
	logic signed [W-1:0]     dd;
	logic [2:0]              neg_d;
	logic                    vnz;
	logic [2*W-1:0]          prod [0:2];
	logic                    valid_s2;
	bpo_flags_t              flags_s2;
	logic [2*W-2:0]          sq_s2 [0:2];
	logic [W-1:0]            dm_s2;

	assign adv      = !valid_s2 || req_ready;
	assign in_ready = adv;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			amin_d[j] = sat_add(sat_add(box_a_min[j*W +: W], position_a[j*W +: W]),
				shift_a[j*W +: W]);
			amax_d[j] = sat_add(sat_add(box_a_max[j*W +: W], position_a[j*W +: W]),
				shift_a[j*W +: W]);
			bmin_d[j] = sat_add(sat_add(box_b_min[j*W +: W], position_b[j*W +: W]),
				shift_b[j*W +: W]);
			bmax_d[j] = sat_add(sat_add(box_b_max[j*W +: W], position_b[j*W +: W]),
				shift_b[j*W +: W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			body_s1 <= a_has_body;
			for (int j = 0; j < 3; j++) begin
				amin_s1[j] <= amin_d[j];
				amax_s1[j] <= amax_d[j];
				bmin_s1[j] <= bmin_d[j];
				bmax_s1[j] <= bmax_d[j];
				vel_s1[j]  <= velocity_a[j*W +: W];
			end
		end
	end

	// Overlap, dominant axis (ties favor x, then y) and penetration depth.
	always_comb begin
		hit_d = 1'b1;
		for (int j = 0; j < 3; j++) begin
			if (!(amin_s1[j] <= bmax_s1[j] && amax_s1[j] >= bmin_s1[j])) begin
				hit_d = 1'b0;
			end
			av[j]   = vel_s1[j][W-1] ? W'(-vel_s1[j]) : W'(vel_s1[j]);
			prod[j] = (2*W)'(vel_s1[j] * vel_s1[j]);
		end
		if (av[0] >= av[1] && av[0] >= av[2]) begin
			ksel = 3'b001;
		end else if (av[1] >= av[2]) begin
			ksel = 3'b010;
		end else begin
			ksel = 3'b100;
		end
		dd = ksel[0] ? sat_sub(bmax_s1[0], amin_s1[0]) :
			(ksel[1] ? sat_sub(bmax_s1[1], amin_s1[1]) : sat_sub(bmax_s1[2], amin_s1[2]));
		for (int j = 0; j < 3; j++) begin
			neg_d[j] = vel_s1[j][W-1] ^ ksel[j] ^ dd[W-1];
		end
		vnz = (vel_s1[0] != '0) || (vel_s1[1] != '0) || (vel_s1[2] != '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2.hit     <= hit_d;
			flags_s2.push_en <= hit_d && body_s1 && vnz;
			flags_s2.neg     <= neg_d;
			dm_s2            <= dd[W-1] ? W'(-dd) : W'(dd);
			for (int j = 0; j < 3; j++) begin
				sq_s2[j] <= prod[j][2*W-2:0];
			end
		end
	end

	assign req_valid = valid_s2;
	assign req_flags = flags_s2;
	assign req_dm    = dm_s2;
	assign req_sq[0] = sq_s2[0];
	assign req_sq[1] = sq_s2[1];
	assign req_sq[2] = sq_s2[2];
	assign req_sum   = {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]} + {1'b0, sq_s2[2]};

endmodule

// ----- rtl/bpo_queue.sv -----
// Small request queue between the front end and the back end.
// Depends on bpo_pkg for its depth.
module bpo_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  logic [DW-1:0] push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output logic [DW-1:0] pop_data
);
	import bpo_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	logic [DW-1:0] mem_q [0:FIFO_DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != (AW+1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/bpo_back.sv -----
// Back end: pipelined ratio division, square root, scaling and output register.
// Depends on bpo_pkg.
module bpo_back #(
	parameter int W = 16,
	parameter int F = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bpo_pkg::bpo_flags_t req_flags,
	input  logic [2:0][2*W-2:0] req_sq,
	input  logic [2*W-1:0]      req_sum,
	input  logic [W-1:0]        req_dm,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	output logic [3*W-1:0]      push_vector
);
	import bpo_pkg::*;

	localparam int ND = 2*F + 2;
	localparam int NS = F + 2;
	localparam int T  = ND + NS + 2;
	localparam int QW = 2*F + 3;
	localparam int XW = 2*NS;
	localparam int RW = 2*W + 1;
	localparam int SW = NS + 2;
	localparam int NW = F + 1;
	localparam int PW = NW + W;
	localparam int MW = PW + 1 - F;
	localparam logic [MW-1:0] MAXM = MW'((1 << (W-1)) - 1);
	localparam logic [MW-1:0] MINM = MW'(1 << (W-1));

	logic            en;
	logic            vld_q  [0:T-1];
	bpo_flags_t      flg_q  [0:T-1];
	logic [W-1:0]    dm_q   [0:T-1];
	logic [RW-1:0]   den_q  [0:ND];
	logic [RW-1:0]   rem_q  [0:ND][0:2];
	logic [QW-1:0]   quo_q  [0:ND][0:2];
	logic [RW-1:0]   rem_d  [0:ND][0:2];
	logic [QW-1:0]   quo_d  [0:ND][0:2];
	logic [XW-1:0]   sx_q   [1:NS][0:2];
	logic [SW-1:0]   srem_q [1:NS][0:2];
	logic [NS-1:0]   sroot_q[1:NS][0:2];
	logic [XW-1:0]   sx_d   [1:NS][0:2];
	logic [SW-1:0]   srem_d [1:NS][0:2];
	logic [NS-1:0]   sroot_d[1:NS][0:2];
	logic [PW-1:0]   prod_q [0:2];
	logic [NS:0]     nsum   [0:2];
	logic [W-1:0]    pv_d   [0:2];
	logic            out_valid_q;
	logic            hit_q;
	logic [3*W-1:0]  push_q;

	assign en        = !out_valid_q || out_ready;
	assign req_ready = en;

	// Restoring division: one quotient bit per stage.
	always_comb begin
		logic [RW-1:0] t;
		logic [RW-1:0] dn;
		logic [XW-1:0] x;
		logic [SW-1:0] r;
		logic [NS-1:0] rt;
		logic [SW-1:0] cand;
		logic [SW-1:0] trial;
		for (int l = 0; l < 3; l++) begin
			t  = {2'b00, req_sq[l]};
			dn = {1'b0, req_sum};
			if (t >= dn) begin
				rem_d[0][l] = t - dn;
				quo_d[0][l] = QW'(1);
			end else begin
				rem_d[0][l] = t;
				quo_d[0][l] = '0;
			end
			for (int i = 1; i <= ND; i++) begin
				t = {rem_q[i-1][l][RW-2:0], 1'b0};
				if (t >= den_q[i-1]) begin
					rem_d[i][l] = t - den_q[i-1];
					quo_d[i][l] = {quo_q[i-1][l][QW-2:0], 1'b1};
				end else begin
					rem_d[i][l] = t;
					quo_d[i][l] = {quo_q[i-1][l][QW-2:0], 1'b0};
				end
			end
			// Digit-by-digit integer square root, one root bit per stage.
			for (int s = 1; s <= NS; s++) begin
				if (s == 1) begin
					x  = {1'b0, quo_q[ND][l]};
					r  = '0;
					rt = '0;
				end else begin
					x  = sx_q[s-1][l];
					r  = srem_q[s-1][l];
					rt = sroot_q[s-1][l];
				end
				cand  = {r[SW-3:0], x[XW-1 -: 2]};
				trial = {rt, 2'b01};
				sx_d[s][l] = {x[XW-3:0], 2'b00};
				if (cand >= trial) begin
					srem_d[s][l]  = cand - trial;
					sroot_d[s][l] = {rt[NS-2:0], 1'b1};
				end else begin
					srem_d[s][l]  = cand;
					sroot_d[s][l] = {rt[NS-2:0], 1'b0};
				end
			end
		end
	end

	// Final rounding, sign and saturation of each push component, or zero when push is not enabled.
	always_comb begin
		logic [PW:0]   rnd;
		logic [MW-1:0] m;
		logic          ng;
		for (int l = 0; l < 3; l++) begin
			nsum[l] = {1'b0, sroot_q[NS][l]} + 1'b1;
			rnd = {1'b0, prod_q[l]} + (PW+1)'(1 << (F-1));
			m   = rnd[PW:F];
			ng  = flg_q[T-1].neg[l];
			if (!flg_q[T-1].push_en) begin
				pv_d[l] = '0;
			end else if (!ng && m > MAXM) begin
				pv_d[l] = {1'b0, {(W-1){1'b1}}};
			end else if (ng && m > MINM) begin
				pv_d[l] = {1'b1, {(W-1){1'b0}}};
			end else if (ng) begin
				pv_d[l] = W'(-m);
			end else begin
				pv_d[l] = m[W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < T; i++) begin
				vld_q[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= req_valid;
			for (int i = 1; i < T; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			out_valid_q <= vld_q[T-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_q[0] <= req_flags;
			dm_q[0]  <= req_dm;
			den_q[0] <= {1'b0, req_sum};
			for (int i = 1; i < T; i++) begin
				flg_q[i] <= flg_q[i-1];
				dm_q[i]  <= dm_q[i-1];
			end
			for (int i = 1; i <= ND; i++) begin
				den_q[i] <= den_q[i-1];
			end
			for (int l = 0; l < 3; l++) begin
				for (int i = 0; i <= ND; i++) begin
					rem_q[i][l] <= rem_d[i][l];
					quo_q[i][l] <= quo_d[i][l];
				end
				for (int s = 1; s <= NS; s++) begin
					sx_q[s][l]    <= sx_d[s][l];
					srem_q[s][l]  <= srem_d[s][l];
					sroot_q[s][l] <= sroot_d[s][l];
				end
				prod_q[l] <= PW'(nsum[l][NW:1] * dm_q[T-2]);
				push_q[l*W +: W] <= pv_d[l];
			end
			hit_q <= flg_q[T-1].hit;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign push_vector = push_q;

endmodule

// ----- rtl/box_pair_overlap_push_vector_top.sv -----
// Top level of the box pair overlap test with velocity push vector.
// Depends on bpo_pkg, bpo_front, bpo_queue and bpo_back.
//
// This block takes one box pair request per clock cycle while in_ready is high
// and returns one result per request, in order. A request is accepted when
// in_valid and in_ready are both high; a result is taken when out_valid and
// out_ready are both high. Each request moves both boxes into world space with
// saturating adds, tests them for overlap on all three axes (touching counts),
// and, when they hit and the first box has a body and a nonzero velocity,
// produces the push vector: the unit velocity with its dominant axis negated,
// scaled by the depth along that axis. The front end is two register stages
// (world transform, then overlap test, dominant axis and velocity squares). A
// four-entry queue decouples it from the back end, which holds 2*FRAC_BITS+3
// division stages, FRAC_BITS+2 square root stages, one multiply stage and the
// output register. With no stalls, throughput is one request per cycle; when
// out_valid is high and out_ready is low the back end holds, the queue fills
// with four requests and the two front stages hold two more before in_ready
// drops.
module box_pair_overlap_push_vector_top #(
	parameter int FRAC_BITS  = 8,
	parameter int COMP_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [3*COMP_WIDTH-1:0] box_a_min,
	input  logic [3*COMP_WIDTH-1:0] box_a_max,
	input  logic [3*COMP_WIDTH-1:0] box_b_min,
	input  logic [3*COMP_WIDTH-1:0] box_b_max,
	input  logic [3*COMP_WIDTH-1:0] position_a,
	input  logic [3*COMP_WIDTH-1:0] position_b,
	input  logic [3*COMP_WIDTH-1:0] shift_a,
	input  logic [3*COMP_WIDTH-1:0] shift_b,
	input  logic [3*COMP_WIDTH-1:0] velocity_a,
	input  logic                    a_has_body,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic [3*COMP_WIDTH-1:0] push_vector
);
	import bpo_pkg::*;

	localparam int W   = COMP_WIDTH;
	localparam int SQW = 2*W - 1;
	localparam int QDW = FLAGS_W + 3*SQW + 2*W + W;

	// Front end output request.
	logic                f_valid;
	logic                f_ready;
	bpo_flags_t          f_flags;
	logic [2:0][SQW-1:0] f_sq;
	logic [2*W-1:0]      f_sum;
	logic [W-1:0]        f_dm;

	// Queue output request toward the back end.
	logic                b_valid;
	logic                b_ready;
	logic [QDW-1:0]      q_in;
	logic [QDW-1:0]      q_out;
	bpo_flags_t          b_flags;
	logic [2:0][SQW-1:0] b_sq;
	logic [2*W-1:0]      b_sum;
	logic [W-1:0]        b_dm;

	bpo_front #(.W(W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.box_a_min  (box_a_min),
		.box_a_max  (box_a_max),
		.box_b_min  (box_b_min),
		.box_b_max  (box_b_max),
		.position_a (position_a),
		.position_b (position_b),
		.shift_a    (shift_a),
		.shift_b    (shift_b),
		.velocity_a (velocity_a),
		.a_has_body (a_has_body),
		.req_valid  (f_valid),
		.req_ready  (f_ready),
		.req_flags  (f_flags),
		.req_sq     (f_sq),
		.req_sum    (f_sum),
		.req_dm     (f_dm)
	);

	assign q_in = {f_flags, f_sq, f_sum, f_dm};

	bpo_queue #(.DW(QDW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_in),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_out)
	);

	assign {b_flags, b_sq, b_sum, b_dm} = q_out;

	bpo_back #(.W(W), .F(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (b_valid),
		.req_ready   (b_ready),
		.req_flags   (b_flags),
		.req_sq      (b_sq),
		.req_sum     (b_sum),
		.req_dm      (b_dm),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.push_vector (push_vector)
	);

	// A nonzero push vector only ever comes with a hit.
	a_push_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && push_vector != '0) |-> hit)
		else $error("push vector without hit");

	// A request that is not a hit never carries the push enable.
	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_flags.hit) |-> !f_flags.push_en)
		else $error("push enabled on a miss");

	// The back end only pulls from the queue while the output side can move.
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !b_ready)
		else $error("back end advanced while output stalled");

endmodule
